@@ design/segment_intersection_test_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection test unit
// Shared property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SITM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, disabled in reset
`define SITM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error(msg);

// checked on every edge, reset included
`define SITM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
	else $error(msg);

`endif

@@ design/sitm_pkg.sv @@
// ----------------------------------------------------------------------------
// sitm_pkg
// Types and fixed constants shared by the segment intersection test unit.
// ----------------------------------------------------------------------------
package sitm_pkg;

	typedef enum logic [1:0] {
		KIND_HORIZ,
		KIND_PARALLEL,
		KIND_GENERAL
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  hit;
	} ctrl_t;

	localparam int QUO_W      = 32;
	localparam int DIV_LAT    = QUO_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [QUO_W-1:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

@@ design/sitm_if.sv @@
// ----------------------------------------------------------------------------
// sitm_if
// Valid/ready channels: segment pair in, intersection result out.
// ----------------------------------------------------------------------------
interface sitm_in_if #(parameter int COORD_WIDTH = 16) ();
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] a_start_x;
	logic signed [COORD_WIDTH-1:0] a_start_y;
	logic signed [COORD_WIDTH-1:0] a_end_x;
	logic signed [COORD_WIDTH-1:0] a_end_y;
	logic signed [COORD_WIDTH-1:0] b_start_x;
	logic signed [COORD_WIDTH-1:0] b_start_y;
	logic signed [COORD_WIDTH-1:0] b_end_x;
	logic signed [COORD_WIDTH-1:0] b_end_y;

	modport source (
		output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		output b_start_x, b_start_y, b_end_x, b_end_y,
		input  ready
	);
	modport sink (
		input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
		input  b_start_x, b_start_y, b_end_x, b_end_y,
		output ready
	);
endinterface

interface sitm_out_if ();
	logic valid;
	logic ready;
	logic collide;
	logic point_valid;
	logic signed [31:0] cross_x;
	logic signed [31:0] cross_y;

	modport source (output valid, collide, point_valid, cross_x, cross_y, input ready);
	modport sink (input valid, collide, point_valid, cross_x, cross_y, output ready);
endinterface

@@ design/sitm_mul.sv @@
// ----------------------------------------------------------------------------
// sitm_mul
// Two-stage signed multiplier: B split in halves, partial products summed.
// ----------------------------------------------------------------------------
module sitm_mul #(
	parameter int A_W = 17,
	parameter int B_W = 35
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [B_W-1:0]   b,
	output logic signed [A_W+B_W-1:0] p
);
	localparam int LO_W = B_W / 2;
	localparam int HI_W = B_W - LO_W;
	localparam int P_W  = A_W + B_W;

	logic signed [LO_W:0]         b_lo;
	logic signed [HI_W-1:0]       b_hi;
	logic signed [A_W+LO_W:0]     plo_s1;
	logic signed [A_W+HI_W-1:0]   phi_s1;
	logic signed [P_W-1:0]        p_s2;

	assign b_lo = $signed({1'b0, b[LO_W-1:0]});
	assign b_hi = b[B_W-1:LO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= a * b_lo;
			phi_s1 <= a * b_hi;
			p_s2   <= $signed({phi_s1, {LO_W{1'b0}}}) + P_W'(plo_s1);
		end
	end

	assign p = p_s2;
endmodule

@@ design/sitm_div.sv @@
// ----------------------------------------------------------------------------
// sitm_div
// Pipelined restoring divider, one quotient bit per stage, with 32-bit
// signed saturation of the truncated quotient.
// ----------------------------------------------------------------------------
module sitm_div #(
	parameter int NUM_W = 57,
	parameter int DEN_W = 35
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	input  logic                 neg,
	output logic signed [31:0]   quo
);
	import sitm_pkg::*;

	localparam int NX = QUO_W + DEN_W;

	logic [NX-1:0]    numx;
	logic [DEN_W-1:0] rem_s  [QUO_W+1];
	logic [QUO_W-1:0] low_s  [QUO_W+1];
	logic [QUO_W-1:0] quo_s  [QUO_W+1];
	logic [DEN_W-1:0] den_s  [QUO_W+1];
	logic             neg_s  [QUO_W+1];
	logic             ovf_s  [QUO_W+1];
	logic [DEN_W:0]   trial  [QUO_W];
	logic [DEN_W:0]   diff   [QUO_W];
	logic             ge     [QUO_W];
	logic [QUO_W-1:0] q_fin;

	assign numx = NX'(num);

	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			trial[k] = {rem_s[k], low_s[k][QUO_W-1]};
			diff[k]  = trial[k] - {1'b0, den_s[k]};
			ge[k]    = trial[k] >= {1'b0, den_s[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// quotient fits 32 bits only when the high part is below the divisor
			rem_s[0] <= numx[NX-1:QUO_W];
			low_s[0] <= numx[QUO_W-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			ovf_s[0] <= numx[NX-1:QUO_W] >= den;
			for (int k = 0; k < QUO_W; k++) begin
				rem_s[k+1] <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
				low_s[k+1] <= {low_s[k][QUO_W-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge[k]};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign q_fin = quo_s[QUO_W];

	always_comb begin
		if (neg_s[QUO_W]) begin
			if (ovf_s[QUO_W] || q_fin > SAT_NEG) quo = $signed(SAT_NEG);
			else                                 quo = $signed(-q_fin);
		end else begin
			if (ovf_s[QUO_W] || q_fin > SAT_POS) quo = $signed(SAT_POS);
			else                                 quo = $signed(q_fin);
		end
	end
endmodule

@@ design/sitm_fifo.sv @@
// ----------------------------------------------------------------------------
// sitm_fifo
// Small register queue between the classifier and the solver.
// ----------------------------------------------------------------------------
module sitm_fifo #(
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	import sitm_pkg::*;

	logic [DATA_W-1:0]  mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = cnt_q != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

@@ design/sitm_front.sv @@
// ----------------------------------------------------------------------------
// sitm_front
// Three-stage classifier: differences, line products, determinant and
// parameter numerators, then case selection and range tests.
// ----------------------------------------------------------------------------
module sitm_front #(
	parameter int COORD_WIDTH = 16,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * DW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sitm_in_if.sink                       seg_in,
	output logic                          q_valid,
	input  logic                          q_ready,
	output sitm_pkg::ctrl_t               q_ctrl,
	output logic signed [COORD_WIDTH-1:0] q_ax1,
	output logic signed [COORD_WIDTH-1:0] q_ay1,
	output logic signed [DW-1:0]          q_dax,
	output logic signed [DW-1:0]          q_day,
	output logic signed [DW-1:0]          q_dby,
	output logic signed [PW-1:0]          q_den,
	output logic signed [PW-1:0]          q_tn,
	output logic signed [PW-1:0]          q_ca,
	output logic signed [PW-1:0]          q_cb
);
	import sitm_pkg::*;

	localparam int MW = 2 * DW;

	function automatic logic in_unit(input logic signed [PW-1:0] n, input logic signed [PW-1:0] d);
		logic pos;
		pos = !d[PW-1] && (d != '0);
		return pos ? (!n[PW-1] && n <= d) : ((n[PW-1] || n == '0) && n >= d);
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [COORD_WIDTH-1:0] ax1_s1, ay1_s1, bx1_s1, by1_s1;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, wx_s1, wy_s1;
	logic horiz_s1, hz_hit_s1, y_ov_s1;

	logic signed [MW-1:0] pd1_s2, pd2_s2, pt1_s2, pt2_s2, pu1_s2, pu2_s2;
	logic signed [MW-1:0] pa1_s2, pa2_s2, pb1_s2, pb2_s2;
	logic signed [COORD_WIDTH-1:0] ax1_s2, ay1_s2;
	logic signed [DW-1:0] dax_s2, day_s2, dbx_s2, dby_s2;
	logic horiz_s2, hz_hit_s2, y_ov_s2;

	logic signed [PW-1:0] den_s3, tn_s3, un_s3, ca_s3, cb_s3;
	logic signed [COORD_WIDTH-1:0] ax1_s3, ay1_s3;
	logic signed [DW-1:0] dax_s3, day_s3, dbx_s3, dby_s3;
	logic horiz_s3, hz_hit_s3, y_ov_s3;

	logic den_zero, iu_t, iu_u, gen_hit;

	assign en           = !v_s3 || q_ready;
	assign seg_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax1_s1 <= seg_in.a_start_x;
			ay1_s1 <= seg_in.a_start_y;
			bx1_s1 <= seg_in.b_start_x;
			by1_s1 <= seg_in.b_start_y;
			dax_s1 <= DW'(seg_in.a_end_x) - DW'(seg_in.a_start_x);
			day_s1 <= DW'(seg_in.a_end_y) - DW'(seg_in.a_start_y);
			dbx_s1 <= DW'(seg_in.b_end_x) - DW'(seg_in.b_start_x);
			dby_s1 <= DW'(seg_in.b_end_y) - DW'(seg_in.b_start_y);
			wx_s1  <= DW'(seg_in.b_start_x) - DW'(seg_in.a_start_x);
			wy_s1  <= DW'(seg_in.b_start_y) - DW'(seg_in.a_start_y);
			horiz_s1 <= (seg_in.a_start_y == seg_in.a_end_y) &&
			            (seg_in.b_start_y == seg_in.b_end_y);
			// half-open overlaps
			hz_hit_s1 <= (seg_in.a_start_y == seg_in.b_start_y) &&
			             ((seg_in.b_start_x <= seg_in.a_start_x &&
			               seg_in.a_start_x < seg_in.b_end_x) ||
			              (seg_in.a_start_x <= seg_in.b_start_x &&
			               seg_in.b_start_x < seg_in.a_end_x));
			y_ov_s1 <= (seg_in.b_start_y <= seg_in.a_start_y &&
			            seg_in.a_start_y < seg_in.b_end_y) ||
			           (seg_in.a_start_y <= seg_in.b_start_y &&
			            seg_in.b_start_y < seg_in.a_end_y);

			pd1_s2 <= dax_s1 * dby_s1;
			pd2_s2 <= day_s1 * dbx_s1;
			pt1_s2 <= wx_s1 * dby_s1;
			pt2_s2 <= wy_s1 * dbx_s1;
			pu1_s2 <= wx_s1 * day_s1;
			pu2_s2 <= wy_s1 * dax_s1;
			pa1_s2 <= DW'(ax1_s1) * day_s1;
			pa2_s2 <= DW'(ay1_s1) * dax_s1;
			pb1_s2 <= DW'(bx1_s1) * dby_s1;
			pb2_s2 <= DW'(by1_s1) * dbx_s1;
			ax1_s2 <= ax1_s1;
			ay1_s2 <= ay1_s1;
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			dbx_s2 <= dbx_s1;
			dby_s2 <= dby_s1;
			horiz_s2  <= horiz_s1;
			hz_hit_s2 <= hz_hit_s1;
			y_ov_s2   <= y_ov_s1;

			den_s3 <= PW'(pd1_s2) - PW'(pd2_s2);
			tn_s3  <= PW'(pt1_s2) - PW'(pt2_s2);
			un_s3  <= PW'(pu1_s2) - PW'(pu2_s2);
			ca_s3  <= PW'(pa1_s2) - PW'(pa2_s2);
			cb_s3  <= PW'(pb1_s2) - PW'(pb2_s2);
			ax1_s3 <= ax1_s2;
			ay1_s3 <= ay1_s2;
			dax_s3 <= dax_s2;
			day_s3 <= day_s2;
			dbx_s3 <= dbx_s2;
			dby_s3 <= dby_s2;
			horiz_s3  <= horiz_s2;
			hz_hit_s3 <= hz_hit_s2;
			y_ov_s3   <= y_ov_s2;
		end
	end

	assign den_zero = den_s3 == '0;
	assign iu_t     = in_unit(tn_s3, den_s3);
	assign iu_u     = in_unit(un_s3, den_s3);
	// b's range is tested on the same axis as a's; skipped when b is flat on it
	assign gen_hit  = iu_t && ((dax_s3 != '0) ? (dbx_s3 == '0 || iu_u)
	                                          : (dby_s3 == '0 || iu_u));

	always_comb begin
		if (horiz_s3) begin
			q_ctrl.kind = KIND_HORIZ;
			q_ctrl.hit  = hz_hit_s3;
		end else if (den_zero) begin
			q_ctrl.kind = KIND_PARALLEL;
			q_ctrl.hit  = y_ov_s3;
		end else begin
			q_ctrl.kind = KIND_GENERAL;
			q_ctrl.hit  = gen_hit;
		end
	end

	assign q_valid = v_s3;
	assign q_ax1   = ax1_s3;
	assign q_ay1   = ay1_s3;
	assign q_dax   = dax_s3;
	assign q_day   = day_s3;
	assign q_dby   = dby_s3;
	assign q_den   = den_s3;
	assign q_tn    = tn_s3;
	assign q_ca    = ca_s3;
	assign q_cb    = cb_s3;
endmodule

@@ design/sitm_back.sv @@
// ----------------------------------------------------------------------------
// sitm_back
// Solver: wide products for the crossing numerators and the collinear test,
// magnitude split, two dividers, and the result register.
// ----------------------------------------------------------------------------
module sitm_back #(
	parameter int COORD_WIDTH = 16,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * DW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  sitm_pkg::ctrl_t               q_ctrl,
	input  logic signed [COORD_WIDTH-1:0] q_ax1,
	input  logic signed [COORD_WIDTH-1:0] q_ay1,
	input  logic signed [DW-1:0]          q_dax,
	input  logic signed [DW-1:0]          q_day,
	input  logic signed [DW-1:0]          q_dby,
	input  logic signed [PW-1:0]          q_den,
	input  logic signed [PW-1:0]          q_tn,
	input  logic signed [PW-1:0]          q_ca,
	input  logic signed [PW-1:0]          q_cb,
	sitm_out_if.source                    res_out
);
	import sitm_pkg::*;

	localparam int MP = DW + PW;
	localparam int NW = MP + 1;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic signed [PW-1:0] den_s1, den_s2, den_s3;
	logic signed [DW-1:0] ax1_x, ay1_x;
	logic signed [MP-1:0] mx1, mx2, my1, my2, ml, mr;
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic eq_s3, eq_s4;
	logic [NW-1:0] nxm_s4, nym_s4;
	logic [PW-1:0] dm_s4;
	logic negx_s4, negy_s4;

	logic  v_sd    [DIV_LAT];
	ctrl_t ctrl_sd [DIV_LAT];
	logic  eq_sd   [DIV_LAT];
	logic signed [31:0] qx, qy;

	logic out_v_q, collide_q, pv_q;
	logic signed [31:0] cx_q, cy_q;

	assign en      = !out_v_q || res_out.ready;
	assign q_ready = en;
	assign ax1_x   = DW'(q_ax1);
	assign ay1_x   = DW'(q_ay1);

	sitm_mul #(.A_W(DW), .B_W(PW)) u_mx1 (.clk(clk), .en(en), .a(ax1_x), .b(q_den), .p(mx1));
	sitm_mul #(.A_W(DW), .B_W(PW)) u_mx2 (.clk(clk), .en(en), .a(q_dax), .b(q_tn),  .p(mx2));
	sitm_mul #(.A_W(DW), .B_W(PW)) u_my1 (.clk(clk), .en(en), .a(ay1_x), .b(q_den), .p(my1));
	sitm_mul #(.A_W(DW), .B_W(PW)) u_my2 (.clk(clk), .en(en), .a(q_day), .b(q_tn),  .p(my2));
	sitm_mul #(.A_W(DW), .B_W(PW)) u_ml  (.clk(clk), .en(en), .a(q_day), .b(q_cb),  .p(ml));
	sitm_mul #(.A_W(DW), .B_W(PW)) u_mr  (.clk(clk), .en(en), .a(q_dby), .b(q_ca),  .p(mr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) v_sd[k] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sd[0] <= v_s4;
			for (int k = 1; k < DIV_LAT; k++) v_sd[k] <= v_sd[k-1];
			out_v_q <= v_sd[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= q_ctrl;
			den_s1  <= q_den;
			ctrl_s2 <= ctrl_s1;
			den_s2  <= den_s1;

			ctrl_s3 <= ctrl_s2;
			den_s3  <= den_s2;
			nx_s3   <= NW'(mx1) + NW'(mx2);
			ny_s3   <= NW'(my1) + NW'(my2);
			eq_s3   <= ml == mr;

			ctrl_s4 <= ctrl_s3;
			eq_s4   <= eq_s3;
			nxm_s4  <= nx_s3[NW-1] ? unsigned'(-nx_s3) : unsigned'(nx_s3);
			nym_s4  <= ny_s3[NW-1] ? unsigned'(-ny_s3) : unsigned'(ny_s3);
			dm_s4   <= den_s3[PW-1] ? unsigned'(-den_s3) : unsigned'(den_s3);
			negx_s4 <= nx_s3[NW-1] ^ den_s3[PW-1];
			negy_s4 <= ny_s3[NW-1] ^ den_s3[PW-1];

			ctrl_sd[0] <= ctrl_s4;
			eq_sd[0]   <= eq_s4;
			for (int k = 1; k < DIV_LAT; k++) begin
				ctrl_sd[k] <= ctrl_sd[k-1];
				eq_sd[k]   <= eq_sd[k-1];
			end

			case (ctrl_sd[DIV_LAT-1].kind)
				KIND_GENERAL: begin
					collide_q <= ctrl_sd[DIV_LAT-1].hit;
					pv_q      <= 1'b1;
					cx_q      <= qx;
					cy_q      <= qy;
				end
				KIND_PARALLEL: begin
					collide_q <= ctrl_sd[DIV_LAT-1].hit && eq_sd[DIV_LAT-1];
					pv_q      <= 1'b0;
					cx_q      <= '0;
					cy_q      <= '0;
				end
				default: begin
					collide_q <= ctrl_sd[DIV_LAT-1].hit;
					pv_q      <= 1'b0;
					cx_q      <= '0;
					cy_q      <= '0;
				end
			endcase
		end
	end

	sitm_div #(.NUM_W(NW), .DEN_W(PW)) u_divx (
		.clk(clk), .en(en), .num(nxm_s4), .den(dm_s4), .neg(negx_s4), .quo(qx)
	);
	sitm_div #(.NUM_W(NW), .DEN_W(PW)) u_divy (
		.clk(clk), .en(en), .num(nym_s4), .den(dm_s4), .neg(negy_s4), .quo(qy)
	);

	assign res_out.valid       = out_v_q;
	assign res_out.collide     = collide_q;
	assign res_out.point_valid = pv_q;
	assign res_out.cross_x     = cx_q;
	assign res_out.cross_y     = cy_q;
endmodule

@@ design/segment_intersection_test_unit.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test_unit
// Decides whether two integer segments touch and gives the crossing point.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  seg_in    sink       a/b start and end points, COORD_WIDTH bits signed
//  res_out   source     collide, point_valid, cross_x, cross_y (32b signed)
//
// One pair per cycle sustained while res_out.ready stays high; the restoring
// dividers sit behind the split wide multipliers.
// A 4-entry queue separates the classifier from the solver; each side stalls
// on its own ready. arst_n clears all valid and queue state, no clearing pass.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit #(
	parameter int COORD_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sitm_in_if.sink    seg_in,
	sitm_out_if.source res_out
);
	import sitm_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW + 1;
	localparam int QW = $bits(ctrl_t) + 2 * COORD_WIDTH + 3 * DW + 4 * PW;

	logic f_valid, f_ready, b_valid, b_ready;
	ctrl_t f_ctrl, b_ctrl;
	logic signed [COORD_WIDTH-1:0] f_ax1, f_ay1, b_ax1, b_ay1;
	logic signed [DW-1:0] f_dax, f_day, f_dby, b_dax, b_day, b_dby;
	logic signed [PW-1:0] f_den, f_tn, f_ca, f_cb, b_den, b_tn, b_ca, b_cb;
	logic [QW-1:0] push_data, pop_data;

	sitm_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .seg_in(seg_in),
		.q_valid(f_valid), .q_ready(f_ready), .q_ctrl(f_ctrl),
		.q_ax1(f_ax1), .q_ay1(f_ay1), .q_dax(f_dax), .q_day(f_day), .q_dby(f_dby),
		.q_den(f_den), .q_tn(f_tn), .q_ca(f_ca), .q_cb(f_cb)
	);

	assign push_data = {f_ctrl, f_ax1, f_ay1, f_dax, f_day, f_dby, f_den, f_tn, f_ca, f_cb};

	sitm_fifo #(.DATA_W(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_data(push_data),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(pop_data)
	);

	assign {b_ctrl, b_ax1, b_ay1, b_dax, b_day, b_dby, b_den, b_tn, b_ca, b_cb} = pop_data;

	sitm_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(b_valid), .q_ready(b_ready), .q_ctrl(b_ctrl),
		.q_ax1(b_ax1), .q_ay1(b_ay1), .q_dax(b_dax), .q_day(b_day), .q_dby(b_dby),
		.q_den(b_den), .q_tn(b_tn), .q_ca(b_ca), .q_cb(b_cb),
		.res_out(res_out)
	);
endmodule

@@ design/sitm_checker.sv @@
// ----------------------------------------------------------------------------
// sitm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_intersection_test_unit_assert.svh"

module sitm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        collide,
	input logic        point_valid,
	input logic [31:0] cross_x,
	input logic [31:0] cross_y
);
	`SITM_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`SITM_ASSERT_NEXT(a_data_hold, clk, arst_n, out_valid && !out_ready, $stable(collide) && $stable(point_valid) && $stable(cross_x) && $stable(cross_y), "result changed while stalled")
	`SITM_ASSERT_IMPLY(a_no_point_zero, clk, arst_n, out_valid && !point_valid, cross_x == 32'd0 && cross_y == 32'd0, "point fields set without a crossing point")
	`SITM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n, !out_valid, "result valid during reset")
endmodule

bind segment_intersection_test_unit sitm_checker u_sitm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(res_out.valid),
	.out_ready(res_out.ready),
	.collide(res_out.collide),
	.point_valid(res_out.point_valid),
	.cross_x(res_out.cross_x),
	.cross_y(res_out.cross_y)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Segment intersection unit testbench
// Drives segment pairs through the input channel with random gaps, predicts
// collide, point_valid and the truncated crossing point with exact integer
// math or a directed vector's given result; checks every transfer in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW        = 16;
	localparam int N_RANDOM  = 1900;
	localparam int LATENCY   = 60;
	localparam longint LIMIT = 400000;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	} seg_pair_t;
	typedef struct {
		logic               collide;
		logic               point_valid;
		logic signed [31:0] cross_x;
		logic signed [31:0] cross_y;
	} crossing_t;
	typedef struct {
		seg_pair_t p;
		logic      known;
		crossing_t r;
	} vector_t;

	logic clk;
	logic arst_n;
	longint cycle_count;
	int mismatches;
	bit stim_done;
	bit rx_hold;
	bit no_idle;
	crossing_t pending_results[$];
	vector_t   directed_vectors[$];

	sitm_in_if #(.COORD_WIDTH(CW)) seg_in ();
	sitm_out_if res_out ();

	segment_intersection_test_unit #(.COORD_WIDTH(CW)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.seg_in (seg_in.sink),
		.res_out(res_out.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// truncated quotient, saturated to 32 bits signed
	function automatic logic signed [31:0] sat_div(logic signed [127:0] n,
			logic signed [127:0] d);
		logic signed [127:0] q;
		q = n / d;
		if (q > 128'sd2147483647)
			return 32'sh7fffffff;
		if (q < -128'sd2147483648)
			return 32'sh80000000;
		return q[31:0];
	endfunction

	function automatic bit in_range(longint n, longint d);
		return d > 0 ? (n >= 0 && n <= d) : (n <= 0 && n >= d);
	endfunction

	function automatic crossing_t predict_crossing(seg_pair_t p);
		crossing_t r;
		longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
		longint dax, day, dbx, dby, det, ca, cb, wx, wy, tn, un;
		logic signed [127:0] lhs, rhs;
		ax1 = p.ax1; ay1 = p.ay1; ax2 = p.ax2; ay2 = p.ay2;
		bx1 = p.bx1; by1 = p.by1; bx2 = p.bx2; by2 = p.by2;
		dax = ax2 - ax1; day = ay2 - ay1; dbx = bx2 - bx1; dby = by2 - by1;
		r = '{1'b0, 1'b0, 32'sd0, 32'sd0};
		if (day == 0 && dby == 0) begin
			r.collide = (ay1 == by1) &&
				((bx1 <= ax1 && ax1 < bx2) || (ax1 <= bx1 && bx1 < ax2));
			return r;
		end
		det = dax * dby - day * dbx;
		if (det == 0) begin
			ca = ax1 * day - ay1 * dax;
			cb = bx1 * dby - by1 * dbx;
			lhs = 128'(day) * 128'(cb);
			rhs = 128'(dby) * 128'(ca);
			r.collide = (lhs == rhs) &&
				((by1 <= ay1 && ay1 < by2) || (ay1 <= by1 && by1 < ay2));
			return r;
		end
		wx = bx1 - ax1;
		wy = by1 - ay1;
		tn = wx * dby - wy * dbx;
		un = wx * day - wy * dax;
		r.collide = in_range(tn, det);
		if (dax != 0) begin
			if (dbx != 0 && !in_range(un, det))
				r.collide = 1'b0;
		end else if (dby != 0 && !in_range(un, det)) begin
			r.collide = 1'b0;
		end
		r.point_valid = 1'b1;
		r.cross_x = sat_div(128'(ax1) * 128'(det) + 128'(dax) * 128'(tn), 128'(det));
		r.cross_y = sat_div(128'(ay1) * 128'(det) + 128'(day) * 128'(tn), 128'(det));
		return r;
	endfunction

	function automatic coord_t rand_coord(int span);
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return coord_t'($urandom_range(0, 2 * span) - span);
		endcase
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int span;
		span = $urandom_range(0, 3) == 0 ? 32767 : 40;
		p.ax1 = rand_coord(span); p.ay1 = rand_coord(span);
		p.ax2 = rand_coord(span); p.ay2 = rand_coord(span);
		p.bx1 = rand_coord(span); p.by1 = rand_coord(span);
		p.bx2 = rand_coord(span); p.by2 = rand_coord(span);
		case ($urandom_range(0, 9))
			0: begin  // both horizontal
				p.ay2 = p.ay1;
				p.by1 = $urandom_range(0, 1) ? p.ay1 : p.by1;
				p.by2 = p.by1;
			end
			1: begin  // parallel, often collinear
				p.bx1 = p.ax1 + coord_t'($urandom_range(0, 6) - 3) * (p.ax2 - p.ax1);
				p.by1 = p.ay1 + coord_t'($urandom_range(0, 6) - 3) * (p.ay2 - p.ay1);
				if ($urandom_range(0, 2) == 0)
					p.by1 = p.by1 + 1;
				p.bx2 = p.bx1 + (p.ax2 - p.ax1) * coord_t'($urandom_range(1, 2));
				p.by2 = p.by1 + (p.ay2 - p.ay1) * coord_t'($urandom_range(1, 2));
			end
			2: p.ax2 = p.ax1;  // a vertical
			3: p.bx2 = p.bx1;  // b vertical
			default: ;
		endcase
		return p;
	endfunction

	function automatic seg_pair_t mk(int v[8]);
		seg_pair_t p;
		p = '{coord_t'(v[0]), coord_t'(v[1]), coord_t'(v[2]), coord_t'(v[3]),
			coord_t'(v[4]), coord_t'(v[5]), coord_t'(v[6]), coord_t'(v[7])};
		return p;
	endfunction

	task automatic add_vector(seg_pair_t p, logic known, crossing_t r);
		directed_vectors.push_back('{p, known, r});
	endtask

	task automatic build_directed();
		crossing_t none;
		none = '{1'b0, 1'b0, 32'sd0, 32'sd0};
		add_vector(mk('{0, 0, 0, 0, 0, 0, 0, 0}), 1'b1, none);
		add_vector(mk('{0, 5, 10, 5, 3, 5, 20, 5}), 1'b1, '{1'b1, 1'b0, 32'sd0, 32'sd0});
		add_vector(mk('{0, 5, 10, 5, 10, 5, 20, 5}), 1'b1, none);
		add_vector(mk('{0, 5, 10, 5, 3, 6, 20, 6}), 1'b1, none);
		add_vector(mk('{0, 0, 4, 4, 2, 2, 6, 6}), 1'b1, '{1'b1, 1'b0, 32'sd0, 32'sd0});
		add_vector(mk('{0, 0, 4, 4, 0, 1, 4, 5}), 1'b1, none);
		add_vector(mk('{0, 0, 10, 10, 0, 10, 10, 0}), 1'b1, '{1'b1, 1'b1, 32'sd5, 32'sd5});
		add_vector(mk('{0, 0, 1, 1, 0, 10, 10, 0}), 1'b1, '{1'b0, 1'b1, 32'sd5, 32'sd5});
		add_vector(mk('{3, -10, 3, 10, -5, 0, 5, 0}), 1'b1, '{1'b1, 1'b1, 32'sd3, 32'sd0});
		add_vector(mk('{-5, 0, 5, 0, 3, -10, 3, 10}), 1'b1, '{1'b1, 1'b1, 32'sd3, 32'sd0});
		add_vector(mk('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}),
			1'b0, none);
		add_vector(mk('{32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768}),
			1'b0, none);
		add_vector(mk('{-32768, 0, 32767, 1, -32768, 0, 32767, 2}), 1'b0, none);
		add_vector(mk('{32767, -32768, -32768, 32767, 0, 0, 1, 1}), 1'b0, none);
		add_vector(mk('{0, 0, 0, 0, 1, 1, 2, 3}), 1'b0, none);
		add_vector(mk('{-7, 3, 9, -11, 2, -20, -3, 17}), 1'b0, none);
		add_vector(mk('{-32768, -32768, -32768, 32767, 32767, -32768, -32767, 32767}),
			1'b0, none);
	endtask

	// valid drops only while idling, so back-to-back pairs keep it high
	task automatic send_pair(seg_pair_t p);
		while (!no_idle && $urandom_range(0, 99) < 34) begin
			seg_in.valid <= 1'b0;
			@(posedge clk);
		end
		seg_in.valid     <= 1'b1;
		seg_in.a_start_x <= p.ax1; seg_in.a_start_y <= p.ay1;
		seg_in.a_end_x   <= p.ax2; seg_in.a_end_y   <= p.ay2;
		seg_in.b_start_x <= p.bx1; seg_in.b_start_y <= p.by1;
		seg_in.b_end_x   <= p.bx2; seg_in.b_end_y   <= p.by2;
		@(posedge clk);
		while (!seg_in.ready)
			@(posedge clk);
	endtask

	task automatic send_checked(seg_pair_t p, logic known, crossing_t r);
		send_pair(p);
		pending_results.push_back(known ? r : predict_crossing(p));
	endtask

	initial begin
		seg_in.valid = 1'b0;
		seg_in.a_start_x = '0; seg_in.a_start_y = '0;
		seg_in.a_end_x = '0; seg_in.a_end_y = '0;
		seg_in.b_start_x = '0; seg_in.b_start_y = '0;
		seg_in.b_end_x = '0; seg_in.b_end_y = '0;
		stim_done = 1'b0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		build_directed();
		foreach (directed_vectors[i])
			send_checked(directed_vectors[i].p, directed_vectors[i].known,
				directed_vectors[i].r);
		for (int n = 0; n < N_RANDOM; n++) begin
			no_idle = (n >= 700 && n < 900);
			// pause until the pipe drains
			if (n == 1200) begin
				seg_in.valid <= 1'b0;
				wait (pending_results.size() == 0);
			end
			send_checked(random_pair(), 1'b0, '{1'b0, 1'b0, 32'sd0, 32'sd0});
		end
		seg_in.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		rx_hold = 1'b0;
		wait (arst_n);
		repeat (300) @(posedge clk);
		rx_hold = 1'b1;
		repeat (200) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		res_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_out.ready <= !rx_hold && (no_idle || $urandom_range(0, 99) >= 34);
		end
	end

	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && res_out.valid && res_out.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer at cycle %0d", cycle_count);
			end else begin
				want = pending_results.pop_front();
				if (res_out.collide !== want.collide
						|| res_out.point_valid !== want.point_valid
						|| res_out.cross_x !== want.cross_x
						|| res_out.cross_y !== want.cross_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cyc %0d exp c=%b pv=%b x=%0d y=%0d got c=%b pv=%b x=%0d y=%0d",
							cycle_count, want.collide, want.point_valid, want.cross_x,
							want.cross_y, res_out.collide, res_out.point_valid,
							res_out.cross_x, res_out.cross_y);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		cycle_count = 0;
		fork
			begin
				wait (stim_done && pending_results.size() == 0);
				repeat (LATENCY) @(posedge clk);
				if (mismatches == 0 && pending_results.size() == 0)
					$display("Simulation PASSED");
				else
					$display("Simulation FAILED");
			end
			begin
				while (cycle_count < LIMIT) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("timeout");
				$display("Simulation FAILED");
			end
		join_any
		$finish;
	end

endmodule
